[design/i2d_pkg.sv]
// shared types and constants for the integer to decimal ascii converter
// no dependencies

package i2d_pkg;

	localparam int MagWidth  = 64;
	localparam int NumDigits = 20;
	localparam int BcdWidth  = 4 * NumDigits;
	localparam int CntWidth  = $clog2(NumDigits + 1);
	localparam int StepWidth = $clog2(MagWidth);

	localparam logic [7:0] CharZero  = 8'h30;
	localparam logic [7:0] CharMinus = 8'h2D;

	typedef enum logic [1:0] {
		KIND_S32 = 2'd0,
		KIND_U32 = 2'd1,
		KIND_S64 = 2'd2,
		KIND_U64 = 2'd3
	} kind_t;

	typedef struct packed {
		logic load;
		logic conv_step;
		logic digit_shift;
		logic sign_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic neg;
		logic top_zero;
		logic last_digit;
	} dp_status_t;

endpackage

[design/i2d_in_if.sv]
// request channel: integer kind and raw value bits
// depends on i2d_pkg

interface i2d_in_if;
	import i2d_pkg::*;

	logic                valid;
	logic                ready;
	logic [1:0]          req_type;
	logic [MagWidth-1:0] value_bits;

	modport source (output valid, output req_type, output value_bits, input ready);
	modport sink (input valid, input req_type, input value_bits, output ready);
endinterface

[design/i2d_out_if.sv]
// result channel: one ascii character per transfer
// no dependencies

interface i2d_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic       last_char;

	modport source (output valid, output char_out, output last_char, input ready);
	modport sink (input valid, input char_out, input last_char, output ready);
endinterface

[design/integer_to_decimal_ascii.sv]
// top level: integer to decimal ascii text converter
// depends on i2d_pkg, i2d_in_if, i2d_out_if, i2d_ctrl, i2d_datapath
//
// usage:
//   req carries one integer (req_type selects signed/unsigned, 32/64 bit)
//   and value_bits; rsp returns its decimal text one character per
//   transfer, most significant digit first, with last_char on the final one.
//   negative signed values start with '-'; zero gives a single '0'.
//   processing: a load, the shift-add-3 binary to bcd conversion over all
//   64 magnitude bits, then the leading zero digits are dropped (up to 19),
//   after which characters are offered one per cycle while the receiver is
//   ready.
//   one item is in flight at a time; req.ready is high only when idle.
//   a stalled receiver holds the current character stable until taken.
//   reset returns the controller to idle; nothing is kept between items.

module integer_to_decimal_ascii (
	input  logic clk,
	input  logic arst_n,
	i2d_in_if.sink    req,
	i2d_out_if.source rsp
);
	import i2d_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	i2d_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	i2d_datapath u_datapath (
		.clk        (clk),
		.cmd        (cmd),
		.req_type   (req.req_type),
		.value_bits (req.value_bits),
		.status     (status),
		.char_out   (rsp.char_out),
		.last_char  (rsp.last_char)
	);
endmodule

[design/i2d_datapath.sv]
// datapath: magnitude, shift-add-3 bcd conversion and digit output register
// depends on i2d_pkg

module i2d_datapath (
	input  logic                          clk,
	input  i2d_pkg::dp_cmd_t              cmd,
	input  logic [1:0]                    req_type,
	input  logic [i2d_pkg::MagWidth-1:0]  value_bits,
	output i2d_pkg::dp_status_t           status,
	output logic [7:0]                    char_out,
	output logic                          last_char
);
	import i2d_pkg::*;

	logic [MagWidth-1:0] bin_q;
	logic [BcdWidth-1:0] bcd_q;
	logic [CntWidth-1:0] ndig_q;
	logic                neg_q;

	logic [MagWidth-1:0] mag;
	logic                neg;
	logic [31:0]         neg32;
	logic [BcdWidth-1:0] adj;

	always_comb begin
		neg32 = 32'd0 - value_bits[31:0];
		mag   = value_bits;
		neg   = 1'b0;
		case (kind_t'(req_type))
			KIND_S32: begin
				neg = value_bits[31];
				mag = neg ? {32'd0, neg32} : {32'd0, value_bits[31:0]};
			end
			KIND_U32: mag = {32'd0, value_bits[31:0]};
			KIND_S64: begin
				neg = value_bits[MagWidth-1];
				mag = neg ? ({MagWidth{1'b0}} - value_bits) : value_bits;
			end
			default: mag = value_bits;
		endcase
	end

	always_comb begin
		for (int i = 0; i < NumDigits; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q  <= mag;
			bcd_q  <= '0;
			neg_q  <= neg;
			ndig_q <= CntWidth'(NumDigits);
		end else if (cmd.conv_step) begin
			bcd_q <= {adj[BcdWidth-2:0], bin_q[MagWidth-1]};
			bin_q <= {bin_q[MagWidth-2:0], 1'b0};
		end else if (cmd.digit_shift) begin
			bcd_q  <= {bcd_q[BcdWidth-5:0], 4'd0};
			ndig_q <= ndig_q - CntWidth'(1);
		end
	end

	assign status.neg        = neg_q;
	assign status.top_zero   = (bcd_q[BcdWidth-1 -: 4] == 4'd0);
	assign status.last_digit = (ndig_q == CntWidth'(1));

	assign char_out  = cmd.sign_sel ? CharMinus : (CharZero + {4'd0, bcd_q[BcdWidth-1 -: 4]});
	assign last_char = !cmd.sign_sel && status.last_digit;
endmodule

[design/i2d_ctrl.sv]
// controller: sequences load, conversion steps, leading zero skip and emit
// depends on i2d_pkg

module i2d_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  i2d_pkg::dp_status_t  status,
	output i2d_pkg::dp_cmd_t     cmd
);
	import i2d_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} state_t;

	state_t               state_q;
	logic [StepWidth-1:0] step_q;

	logic skip_more;

	assign skip_more = status.top_zero && !status.last_digit;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_SIGN) || (state_q == ST_EMIT);

	always_comb begin
		cmd             = '0;
		cmd.load        = (state_q == ST_IDLE) && in_valid;
		cmd.conv_step   = (state_q == ST_CONV);
		cmd.digit_shift = ((state_q == ST_SKIP) && skip_more) ||
		                  ((state_q == ST_EMIT) && out_ready);
		cmd.sign_sel    = (state_q == ST_SIGN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (in_valid) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					step_q <= step_q + StepWidth'(1);
					if (step_q == {StepWidth{1'b1}}) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (!skip_more) begin
						state_q <= status.neg ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					if (out_ready) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_ready && status.last_digit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[bench/i2d_text_checker.sv]
// checker for the integer to decimal ascii converter: predicts the text of
// each request transfer and compares every response transfer against it
// depends on i2d_pkg, i2d_in_if, i2d_out_if

module i2d_text_checker (
	input  logic clk,
	input  logic arst_n,
	i2d_in_if    req,
	i2d_out_if   rsp,
	output int   err_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import i2d_pkg::*;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_rec_t;

	char_rec_t expected_chars[$];
	int        chars_seen;

	initial begin
		err_count  = 0;
		pending    = 0;
		chars_seen = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch at character %0d: %s", $realtime, chars_seen, msg);
		err_count = err_count + 1;
	endtask

	function automatic void predict_text(input kind_t kind, input logic [63:0] bits);
		logic [63:0] mag;
		logic [31:0] low_neg;
		logic        neg;
		logic [7:0]  digits[NumDigits];
		int          nd;
		char_rec_t   rec;
		neg = 1'b0;
		nd  = 0;
		case (kind)
			KIND_S32: begin
				if (bits[31]) begin
					neg     = 1'b1;
					low_neg = -bits[31:0];
					mag     = {32'd0, low_neg};
				end else begin
					mag = {32'd0, bits[31:0]};
				end
			end
			KIND_U32: mag = {32'd0, bits[31:0]};
			KIND_S64: begin
				neg = bits[63];
				mag = bits[63] ? -bits : bits;
			end
			default: mag = bits;
		endcase
		do begin
			digits[nd] = CharZero + 8'(mag % 64'd10);
			nd++;
			mag = mag / 64'd10;
		end while (mag != 64'd0 && nd < NumDigits);
		if (neg) begin
			rec.ch   = CharMinus;
			rec.last = 1'b0;
			expected_chars.push_back(rec);
		end
		for (int i = nd - 1; i >= 0; i--) begin
			rec.ch   = digits[i];
			rec.last = (i == 0);
			expected_chars.push_back(rec);
		end
	endfunction

	always @(posedge clk) begin
		char_rec_t rec;
		if (arst_n) begin
			if (req.valid && req.ready)
				predict_text(kind_t'(req.req_type), req.value_bits);
			if (rsp.valid && rsp.ready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected char 0x%02h last %b",
						rsp.char_out, rsp.last_char));
				end else begin
					rec = expected_chars.pop_front();
					if (rsp.char_out !== rec.ch)
						report_mismatch($sformatf("char_out 0x%02h, expected 0x%02h",
							rsp.char_out, rec.ch));
					if (rsp.last_char !== rec.last)
						report_mismatch($sformatf("last_char %b, expected %b",
							rsp.last_char, rec.last));
				end
				chars_seen++;
			end
			pending = expected_chars.size();
		end
	end

endmodule

[bench/integer_to_decimal_ascii_tb.sv]
// testbench top for the integer to decimal ascii converter: drives requests
// with directed and random integers under varying idle and stall patterns
// depends on i2d_pkg, i2d_in_if, i2d_out_if, i2d_text_checker, integer_to_decimal_ascii

module integer_to_decimal_ascii_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import i2d_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	int   err_count;
	int   pending;
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	int   hold_cycles    = 0;

	i2d_in_if  req_if();
	i2d_out_if rsp_if();

	integer_to_decimal_ascii u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	i2d_text_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.rsp       (rsp_if),
		.err_count (err_count),
		.pending   (pending)
	);

	always #5ns clk = ~clk;

	initial begin
		#10ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver: random stalls, or a long hold-off while hold_cycles runs down
	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				rsp_if.ready <= 1'b0;
				hold_cycles = hold_cycles - 1;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_item(input kind_t kind, input logic [63:0] bits);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid      <= 1'b1;
		req_if.req_type   <= kind;
		req_if.value_bits <= bits;
		do @(posedge clk); while (!req_if.ready);
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	function automatic logic [63:0] random_bits();
		logic [63:0] v;
		logic [63:0] p;
		int          k;
		v = {$urandom, $urandom};
		case ($urandom_range(3))
			0: ;
			1: v = v >> $urandom_range(63);
			2: begin
				p = 64'd1;
				k = $urandom_range(19);
				repeat (k) p = p * 64'd10;
				v = p - 64'($urandom_range(1));
			end
			default: v = -(v >> $urandom_range(63));
		endcase
		return v;
	endfunction

	initial begin
		req_if.valid      <= 1'b0;
		req_if.req_type   <= KIND_S32;
		req_if.value_bits <= 64'd0;
		arst_n            <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes of every kind, zero, ignored upper bits
		send_item(KIND_S32, 64'd0);
		send_item(KIND_S32, 64'd1);
		send_item(KIND_S32, 64'h0000_0000_FFFF_FFFF);
		send_item(KIND_S32, 64'h0000_0000_7FFF_FFFF);
		send_item(KIND_S32, 64'h0000_0000_8000_0000);
		send_item(KIND_S32, 64'hDEAD_BEEF_0000_3039);
		send_item(KIND_S32, 64'hFFFF_FFFF_8000_0000);
		send_item(KIND_S32, 64'hFFFF_FFFF_0000_0000);
		send_item(KIND_U32, 64'd0);
		send_item(KIND_U32, 64'h0000_0000_FFFF_FFFF);
		send_item(KIND_U32, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(KIND_U32, 64'h1234_5678_0000_000A);
		send_item(KIND_U32, 64'd9);
		send_item(KIND_S64, 64'd0);
		send_item(KIND_S64, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(KIND_S64, 64'h7FFF_FFFF_FFFF_FFFF);
		send_item(KIND_S64, 64'h8000_0000_0000_0000);
		send_item(KIND_S64, -64'd10);
		send_item(KIND_U64, 64'd0);
		send_item(KIND_U64, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(KIND_U64, 64'd10000000000000000000);
		send_item(KIND_U64, 64'd9999999999999999999);
		send_item(KIND_U64, 64'h8000_0000_0000_0000);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
					hold_cycles    = 600;
				end
				1: begin
					send_idle_pct  = 59;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 59;
				end
				default: begin
					send_idle_pct  = 16;
					recv_stall_pct = 16;
				end
			endcase
			for (int i = 0; i < 72; i++)
				send_item(kind_t'($urandom_range(3)), random_bits());
			drain();
		end

		repeat (150) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[sim.f]
design/i2d_pkg.sv
design/i2d_in_if.sv
design/i2d_out_if.sv
design/i2d_datapath.sv
design/i2d_ctrl.sv
design/integer_to_decimal_ascii.sv
bench/i2d_text_checker.sv
bench/integer_to_decimal_ascii_tb.sv
